FILE: rtl/dtti_pkg.sv
// ----------------------------------------------------------------------------
// dtti_pkg
// Shared types and constants for the decimal text to integer converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dtti_pkg;

    // ASCII codes recognised by the parser
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_UPPER_LIMIT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOWER_LIMIT = 2'd2;

    localparam logic [63:0] UPPER_LIMIT_RESET = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LOWER_LIMIT_RESET = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic        signed_mode;
        logic [63:0] upper_limit;
        logic [63:0] lower_limit;
    } cfg_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        logic [63:0] num_value;
        logic        status;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/dtti_in_stage.sv
// ----------------------------------------------------------------------------
// dtti_in_stage
// Input register: captures one character item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module dtti_in_stage
    import dtti_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    input  wire logic  [7:0] s_tdata,
    input  wire logic  s_tlast,
    input  wire logic  take,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // free when empty or the held item leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.char_code   <= s_tdata;
            item_reg.end_of_text <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

FILE: rtl/dtti_accum.sv
// ----------------------------------------------------------------------------
// dtti_accum
// Text state and the per-character update: sign, digit, x10 + digit, range.
// ----------------------------------------------------------------------------
`default_nettype none

module dtti_accum
    import dtti_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  step,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output logic       result_valid,
    output result_t    result
);

    logic [63:0] magnitude_reg, magnitude_next;
    logic        negative_reg, negative_next;
    logic        any_seen_reg, any_seen_next;
    logic        digit_seen_reg, digit_seen_next;
    logic        error_reg, error_next;

    logic        is_sign;
    logic        is_digit;
    logic [3:0]  digit;
    logic [67:0] product;
    logic [63:0] limit;
    logic        too_big;

    assign is_sign  = !any_seen_reg && cfg.signed_mode
                      && (item.char_code == CH_MINUS || item.char_code == CH_PLUS);
    assign is_digit = (item.char_code >= CH_ZERO) && (item.char_code <= CH_NINE);
    assign digit    = item.char_code[3:0];

    // x10 as x8 + x2; top nibble set means the value left 64 bits
    assign product = {1'b0, magnitude_reg, 3'b000} + {3'b000, magnitude_reg, 1'b0}
                     + {64'd0, digit};
    assign limit   = negative_reg ? (64'd0 - cfg.lower_limit) : cfg.upper_limit;
    assign too_big = (product[67:64] != 4'd0) || (product[63:0] > limit);

    always_comb
    begin
        magnitude_next  = magnitude_reg;
        negative_next   = negative_reg;
        any_seen_next   = any_seen_reg;
        digit_seen_next = digit_seen_reg;
        error_next      = error_reg;
        result_valid    = 1'b0;
        result.status   = error_reg || !digit_seen_reg;
        result.num_value = 64'd0;
        if (!result.status)
        begin
            result.num_value = negative_reg ? (64'd0 - magnitude_reg) : magnitude_reg;
        end
        if (step)
        begin
            if (item.end_of_text)
            begin
                result_valid    = 1'b1;
                magnitude_next  = 64'd0;
                negative_next   = 1'b0;
                any_seen_next   = 1'b0;
                digit_seen_next = 1'b0;
                error_next      = 1'b0;
            end
            else if (!error_reg)
            begin
                any_seen_next = 1'b1;
                if (is_sign)
                begin
                    negative_next = (item.char_code == CH_MINUS);
                end
                else if (!is_digit || too_big)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    magnitude_next  = product[63:0];
                    digit_seen_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magnitude_reg  <= 64'd0;
            negative_reg   <= 1'b0;
            any_seen_reg   <= 1'b0;
            digit_seen_reg <= 1'b0;
            error_reg      <= 1'b0;
        end
        else
        begin
            magnitude_reg  <= magnitude_next;
            negative_reg   <= negative_next;
            any_seen_reg   <= any_seen_next;
            digit_seen_reg <= digit_seen_next;
            error_reg      <= error_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dtti_out_stage.sv
// ----------------------------------------------------------------------------
// dtti_out_stage
// Result register on the master side.
// ----------------------------------------------------------------------------
`default_nettype none

module dtti_out_stage
    import dtti_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t result,
    output logic         can_load,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output logic  [63:0] m_tdata,
    output logic         m_tuser
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load   = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = result_reg.num_value;
    assign m_tuser  = result_reg.status;

endmodule

`default_nettype wire

FILE: rtl/decimal_text_to_integer.sv
// ----------------------------------------------------------------------------
// decimal_text_to_integer
// Streaming ASCII decimal parser with configurable range check.
// ----------------------------------------------------------------------------
// Characters of one decimal number arrive one per transfer on the slave side;
// a transfer with s_tlast high ends the text and yields exactly one result:
// the 64-bit value (two's complement when negative) on m_tdata and a status
// bit on m_tuser (0 valid, 1 invalid; m_tdata is then zero). Character
// transfers yield nothing. In signed mode a single leading '-' or '+' is
// taken. Empty text, a lone sign, any non-digit, a value beyond 64 bits or
// beyond the limit (upper_limit, or -lower_limit for negative text) marks the
// text invalid until the terminator. Throughput is one item per clock
// unless a terminator finds the output full. The x10 + digit update
// (shift-add) and limit compare are combinational between input register and
// text state. Terminators pass the input and result registers. Configuration
// writes are always taken and should be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_text_to_integer
    import dtti_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    // character stream
    input  wire logic  s_tvalid,
    output logic       s_tready,
    input  wire logic  [7:0] s_tdata,       // [7:0] char_code
    input  wire logic  s_tlast,             // end_of_text
    // result stream
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output logic       [63:0] m_tdata,      // [63:0] num_value
    output logic       m_tuser,             // [0] status
    // configuration writes
    input  wire logic  cfg_valid,
    output logic       cfg_ready,
    input  wire logic  [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic  [63:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    item_valid;
    item_t   item;
    logic    take;
    logic    out_free;
    logic    result_valid;
    result_t result;

    // Configuration registers; an unknown index is dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.signed_mode <= 1'b0;
            cfg_reg.upper_limit <= UPPER_LIMIT_RESET;
            cfg_reg.lower_limit <= LOWER_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SIGNED_MODE: cfg_reg.signed_mode <= cfg_data[0];
                CFG_UPPER_LIMIT: cfg_reg.upper_limit <= cfg_data;
                CFG_LOWER_LIMIT: cfg_reg.lower_limit <= cfg_data;
                default:         ;
            endcase
        end
    end

    // A character always moves on; a terminator waits for a free result slot
    assign take = item_valid && (!item.end_of_text || out_free);

    dtti_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    dtti_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (take),
        .item         (item),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .result       (result)
    );

    dtti_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (result_valid),
        .result   (result),
        .can_load (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
